>>> hw/rtl/event_ring_queue_with_drop_stats_top_assert.svh
// Assertion macros used by the event ring queue control block
`ifndef EVENT_RING_QUEUE_WITH_DROP_STATS_TOP_ASSERT_SVH
`define EVENT_RING_QUEUE_WITH_DROP_STATS_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ERQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ERQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/erq_pkg.sv
// Types and constants of the event ring queue
package erq_pkg;

	localparam int KIND_W    = 8;
	localparam int SOURCE_W  = 32;
	localparam int PAYLOAD_W = 64;
	localparam int OCC_W     = 8;
	localparam int TOTAL_W   = 64;

	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;

	localparam logic [APB_ADDR_W-1:0] REG_QUEUE_ENABLED = 2'd0;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	localparam logic [KIND_W-1:0] KIND_NONE = 8'd0;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [SOURCE_W-1:0]  source;
		logic [PAYLOAD_W-1:0] payload;
	} erq_event_t;

	typedef struct packed {
		logic       req_type;
		erq_event_t evt;
	} erq_req_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} erq_mem_ctl_t;

	typedef struct packed {
		logic               success;
		logic               popped;
		logic [OCC_W-1:0]   occupancy;
		logic [TOTAL_W-1:0] pushed_total;
		logic [TOTAL_W-1:0] dropped_total;
		logic [TOTAL_W-1:0] popped_total;
	} erq_status_t;

endpackage

>>> hw/rtl/erq_req_if.sv
// Request channel: push or pop with the event to push
interface erq_req_if;
	logic                            valid;
	logic                            ready;
	logic                            req_type;
	logic [erq_pkg::KIND_W-1:0]      event_kind;
	logic [erq_pkg::SOURCE_W-1:0]    event_source;
	logic [erq_pkg::PAYLOAD_W-1:0]   event_payload;

	modport source (output valid, req_type, event_kind, event_source, event_payload,
		input ready);
	modport sink (input valid, req_type, event_kind, event_source, event_payload,
		output ready);
endinterface

>>> hw/rtl/erq_rsp_if.sv
// Result channel: outcome, popped event, occupancy and totals
interface erq_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            success;
	logic [erq_pkg::KIND_W-1:0]      out_kind;
	logic [erq_pkg::SOURCE_W-1:0]    out_source;
	logic [erq_pkg::PAYLOAD_W-1:0]   out_payload;
	logic [erq_pkg::OCC_W-1:0]       occupancy;
	logic [erq_pkg::TOTAL_W-1:0]     pushed_total;
	logic [erq_pkg::TOTAL_W-1:0]     dropped_total;
	logic [erq_pkg::TOTAL_W-1:0]     popped_total;

	modport source (output valid, success, out_kind, out_source, out_payload, occupancy,
		pushed_total, dropped_total, popped_total, input ready);
	modport sink (input valid, success, out_kind, out_source, out_payload, occupancy,
		pushed_total, dropped_total, popped_total, output ready);
endinterface

>>> hw/rtl/event_ring_queue_with_drop_stats_top.sv
// Event ring queue with drop statistics: top level
//
// channel  dir  transfer when        payload
// req      in   req.valid&req.ready  req_type, event_kind, event_source, event_payload
// rsp      out  rsp.valid&rsp.ready  success, out_kind/source/payload, occupancy, totals
// apb      in   psel&penable&pwrite  queue_enabled at byte address 0
//
// One request per cycle while rsp is taken; each result passes the input register,
// then the result register with the registered slot memory read, before it is shown
// on rsp.
// Reset clears indices, totals and the enable; slot memory contents are left as they are.
// A stalled result holds the result stage; the input register still takes one
// more request, after which req.ready drops until rsp is taken.
module event_ring_queue_with_drop_stats_top #(
	parameter int RING_SLOTS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	erq_req_if.sink                         req,
	erq_rsp_if.source                       rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [erq_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [erq_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [erq_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int IdxW = $clog2(RING_SLOTS);

	logic                  enabled;
	erq_pkg::erq_req_t     in_req;
	erq_pkg::erq_status_t  status;
	erq_pkg::erq_mem_ctl_t mem_ctl;
	logic [IdxW-1:0]       wr_addr;
	logic [IdxW-1:0]       rd_addr;
	erq_pkg::erq_event_t   wr_event;
	erq_pkg::erq_event_t   rd_event;
	erq_pkg::erq_event_t   out_event;

	erq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.enabled (enabled)
	);

	assign in_req.req_type    = req.req_type;
	assign in_req.evt.kind    = req.event_kind;
	assign in_req.evt.source  = req.event_source;
	assign in_req.evt.payload = req.event_payload;

	erq_ctrl #(
		.RING_SLOTS (RING_SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.enabled   (enabled),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_req    (in_req),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.mem_ctl   (mem_ctl),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.wr_event  (wr_event)
	);

	erq_store #(
		.RING_SLOTS (RING_SLOTS)
	) u_store (
		.clk      (clk),
		.mem_ctl  (mem_ctl),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.wr_event (wr_event),
		.rd_event (rd_event)
	);

	// show the event only for a pop that returned one
	assign out_event = status.popped ? rd_event : '0;

	assign rsp.success       = status.success;
	assign rsp.out_kind      = out_event.kind;
	assign rsp.out_source    = out_event.source;
	assign rsp.out_payload   = out_event.payload;
	assign rsp.occupancy     = status.occupancy;
	assign rsp.pushed_total  = status.pushed_total;
	assign rsp.dropped_total = status.dropped_total;
	assign rsp.popped_total  = status.popped_total;

endmodule

>>> hw/rtl/erq_cfg.sv
// APB register block holding the queue enable
module erq_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [erq_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [erq_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [erq_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output logic                            enabled
);

	logic enabled_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (wr_en && (paddr == erq_pkg::REG_QUEUE_ENABLED)) begin
			enabled_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == erq_pkg::REG_QUEUE_ENABLED) begin
			prdata[0] = enabled_q;
		end
	end

	assign enabled = enabled_q;

endmodule

>>> hw/rtl/erq_store.sv
// Slot memory with registered read port
module erq_store #(
	parameter int RING_SLOTS = 256,
	localparam int IdxW = $clog2(RING_SLOTS)
) (
	input  logic                  clk,
	input  erq_pkg::erq_mem_ctl_t mem_ctl,
	input  logic [IdxW-1:0]       wr_addr,
	input  logic [IdxW-1:0]       rd_addr,
	input  erq_pkg::erq_event_t   wr_event,
	output erq_pkg::erq_event_t   rd_event
);

	localparam int KsW = erq_pkg::KIND_W + erq_pkg::SOURCE_W;

	logic [erq_pkg::PAYLOAD_W-1:0] slot_payload [RING_SLOTS];
	logic [KsW-1:0]                slot_kind_source [RING_SLOTS];
	logic [erq_pkg::PAYLOAD_W-1:0] rd_payload_s2;
	logic [KsW-1:0]                rd_kind_source_s2;

	always_ff @(posedge clk) begin
		if (mem_ctl.wr) begin
			slot_payload[wr_addr]     <= wr_event.payload;
			slot_kind_source[wr_addr] <= {wr_event.kind, wr_event.source};
		end
	end

	// read data holds until the next pop is taken into the result stage
	always_ff @(posedge clk) begin
		if (mem_ctl.rd) begin
			rd_payload_s2     <= slot_payload[rd_addr];
			rd_kind_source_s2 <= slot_kind_source[rd_addr];
		end
	end

	assign rd_event.kind    = rd_kind_source_s2[KsW-1:erq_pkg::SOURCE_W];
	assign rd_event.source  = rd_kind_source_s2[erq_pkg::SOURCE_W-1:0];
	assign rd_event.payload = rd_payload_s2;

endmodule

>>> hw/rtl/erq_ctrl.sv
// Request decode, ring indices, totals and the two pipeline stages
module erq_ctrl #(
	parameter int RING_SLOTS = 256,
	localparam int IdxW = $clog2(RING_SLOTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  enabled,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  erq_pkg::erq_req_t     in_req,
	output logic                  out_valid,
	input  logic                  out_ready,
	output erq_pkg::erq_status_t  status,
	output erq_pkg::erq_mem_ctl_t mem_ctl,
	output logic [IdxW-1:0]       wr_addr,
	output logic [IdxW-1:0]       rd_addr,
	output erq_pkg::erq_event_t   wr_event
);

	localparam int CntW = IdxW + 1;
	localparam int OccW = erq_pkg::OCC_W;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(RING_SLOTS - 1);
	localparam logic [CntW-1:0] Slots   = CntW'(RING_SLOTS);

	logic                          valid_s1;
	erq_pkg::erq_req_t             req_s1;
	logic                          valid_s2;
	logic                          success_s2;
	logic                          popped_s2;
	logic [IdxW-1:0]               wr_idx_q;
	logic [IdxW-1:0]               rd_idx_q;
	logic [erq_pkg::TOTAL_W-1:0]   push_cnt_q;
	logic [erq_pkg::TOTAL_W-1:0]   drop_cnt_q;
	logic [erq_pkg::TOTAL_W-1:0]   pop_cnt_q;

	logic            adv;
	logic [IdxW-1:0] wr_nxt;
	logic [IdxW-1:0] rd_nxt;
	logic            is_push;
	logic            full;
	logic            push_ok;
	logic            drop;
	logic            pop_ok;
	logic [CntW-1:0] held;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	assign wr_nxt  = (wr_idx_q == LastIdx) ? '0 : wr_idx_q + 1'b1;
	assign rd_nxt  = (rd_idx_q == LastIdx) ? '0 : rd_idx_q + 1'b1;
	assign is_push = enabled && (req_s1.req_type == erq_pkg::REQ_PUSH)
		&& (req_s1.evt.kind != erq_pkg::KIND_NONE);
	assign full    = (wr_nxt == rd_idx_q);
	assign push_ok = is_push && !full;
	assign drop    = is_push && full;
	assign pop_ok  = enabled && (req_s1.req_type == erq_pkg::REQ_POP)
		&& (rd_idx_q != wr_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_req;
		end
	end

	// indices and totals change only as an item moves into the result stage,
	// so they always describe the result on show
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			success_s2 <= 1'b0;
			popped_s2  <= 1'b0;
			wr_idx_q   <= '0;
			rd_idx_q   <= '0;
			push_cnt_q <= '0;
			drop_cnt_q <= '0;
			pop_cnt_q  <= '0;
		end else begin
			if (adv) begin
				valid_s2   <= 1'b1;
				success_s2 <= push_ok || pop_ok;
				popped_s2  <= pop_ok;
				if (push_ok) begin
					wr_idx_q   <= wr_nxt;
					push_cnt_q <= push_cnt_q + 1'b1;
				end
				if (drop) begin
					drop_cnt_q <= drop_cnt_q + 1'b1;
				end
				if (pop_ok) begin
					rd_idx_q  <= rd_nxt;
					pop_cnt_q <= pop_cnt_q + 1'b1;
				end
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign mem_ctl.wr = adv && push_ok;
	assign mem_ctl.rd = adv && pop_ok;
	assign wr_addr    = wr_idx_q;
	assign rd_addr    = rd_idx_q;
	assign wr_event   = req_s1.evt;

	always_comb begin
		held = {1'b0, wr_idx_q} - {1'b0, rd_idx_q};
		if (wr_idx_q < rd_idx_q) begin
			held = held + Slots;
		end
	end

	assign out_valid            = valid_s2;
	assign status.success       = success_s2;
	assign status.popped        = popped_s2;
	assign status.occupancy     = OccW'(held);
	assign status.pushed_total  = push_cnt_q;
	assign status.dropped_total = drop_cnt_q;
	assign status.popped_total  = pop_cnt_q;

`include "event_ring_queue_with_drop_stats_top_assert.svh"

	`ERQ_ASSERT_NXT(a_push_not_empty, clk, arst_n, adv && push_ok,
		wr_idx_q != rd_idx_q, "ring empty after a stored push")
	`ERQ_ASSERT_NXT(a_drop_holds_wr, clk, arst_n, adv && drop,
		$stable(wr_idx_q) && $stable(push_cnt_q), "dropped push moved the write index")
	`ERQ_ASSERT_NXT(a_idle_holds_totals, clk, arst_n, !adv,
		$stable(push_cnt_q) && $stable(drop_cnt_q) && $stable(pop_cnt_q),
		"totals changed without a transfer")
	`ERQ_ASSERT_NXT(a_disabled_fails, clk, arst_n, adv && !enabled,
		!success_s2 && !popped_s2, "request succeeded while disabled")

endmodule

>>> sim/event_ring_queue_with_drop_stats_top_test.sv
// Self-checking testbench of the event ring queue: directed and random push/pop traffic
module event_ring_queue_with_drop_stats_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_SLOTS   = 256;
	localparam int STALL_LIMIT  = 4000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic                          success;
		logic [erq_pkg::KIND_W-1:0]    kind;
		logic [erq_pkg::SOURCE_W-1:0]  source;
		logic [erq_pkg::PAYLOAD_W-1:0] payload;
		logic [erq_pkg::OCC_W-1:0]     occupancy;
		logic [erq_pkg::TOTAL_W-1:0]   pushed;
		logic [erq_pkg::TOTAL_W-1:0]   dropped;
		logic [erq_pkg::TOTAL_W-1:0]   popped;
	} ring_outcome_t;

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [erq_pkg::APB_ADDR_W-1:0] paddr;
	logic [erq_pkg::APB_DATA_W-1:0] pwdata;
	logic [erq_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;

	erq_req_if req_ch();
	erq_rsp_if rsp_ch();

	event_ring_queue_with_drop_stats_top #(.RING_SLOTS(RING_SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// ring model: 256 slots, so 8-bit indices wrap on their own
	erq_pkg::erq_event_t         slot_evt [RING_SLOTS];
	logic [7:0]                  wr_ptr;
	logic [7:0]                  rd_ptr;
	logic [erq_pkg::TOTAL_W-1:0] push_total;
	logic [erq_pkg::TOTAL_W-1:0] drop_total;
	logic [erq_pkg::TOTAL_W-1:0] pop_total;
	logic                        ring_on;

	erq_pkg::erq_req_t pending_reqs [$];
	ring_outcome_t     awaited_outcomes [$];
	erq_pkg::erq_req_t shown_req;
	int                outstanding = 0;
	int                fault_count = 0;
	int unsigned       quiet_cycles = 0;
	int unsigned       send_idle_pct;
	int unsigned       take_idle_pct;

	function automatic ring_outcome_t ring_outcome(erq_pkg::erq_req_t r);
		ring_outcome_t o;
		o = '0;
		if (ring_on) begin
			if (r.req_type == erq_pkg::REQ_PUSH) begin
				if (r.evt.kind != erq_pkg::KIND_NONE) begin
					if (8'(wr_ptr + 8'd1) == rd_ptr) begin
						drop_total = drop_total + 1;
					end else begin
						slot_evt[wr_ptr] = r.evt;
						wr_ptr = wr_ptr + 8'd1;
						push_total = push_total + 1;
						o.success = 1'b1;
					end
				end
			end else if (rd_ptr != wr_ptr) begin
				o.success = 1'b1;
				o.kind = slot_evt[rd_ptr].kind;
				o.source = slot_evt[rd_ptr].source;
				o.payload = slot_evt[rd_ptr].payload;
				rd_ptr = rd_ptr + 8'd1;
				pop_total = pop_total + 1;
			end
		end
		o.occupancy = wr_ptr - rd_ptr;
		o.pushed = push_total;
		o.dropped = drop_total;
		o.popped = pop_total;
		return o;
	endfunction

	function automatic string outcome_text(ring_outcome_t o);
		return $sformatf("ok=%0b kind=%02h src=%08h data=%016h occ=%0d push=%0d drop=%0d pop=%0d",
			o.success, o.kind, o.source, o.payload, o.occupancy, o.pushed, o.dropped, o.popped);
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= erq_pkg::REQ_PUSH;
			req_ch.event_kind <= '0;
			req_ch.event_source <= '0;
			req_ch.event_payload <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_ch.valid)
				awaited_outcomes.push_back(ring_outcome(shown_req));
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				shown_req = pending_reqs.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.req_type <= shown_req.req_type;
				req_ch.event_kind <= shown_req.evt.kind;
				req_ch.event_source <= shown_req.evt.source;
				req_ch.event_payload <= shown_req.evt.payload;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		ring_outcome_t seen;
		ring_outcome_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen = {rsp_ch.success, rsp_ch.out_kind, rsp_ch.out_source, rsp_ch.out_payload,
					rsp_ch.occupancy, rsp_ch.pushed_total, rsp_ch.dropped_total,
					rsp_ch.popped_total};
				if (awaited_outcomes.size() == 0) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display("unexpected result: %s", outcome_text(seen));
				end else begin
					want = awaited_outcomes.pop_front();
					outstanding--;
					if (seen !== want) begin
						fault_count++;
						if (fault_count <= REPORT_LIMIT)
							$display("result mismatch\n  expected %s\n  actual   %s",
								outcome_text(want), outcome_text(seen));
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	// watchdog: give up when nothing moves for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[event_ring_queue_with_drop_stats_top] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic add_req(logic t, logic [erq_pkg::KIND_W-1:0] k,
		logic [erq_pkg::SOURCE_W-1:0] s, logic [erq_pkg::PAYLOAD_W-1:0] p);
		erq_pkg::erq_req_t r;
		r = {t, k, s, p};
		pending_reqs.push_back(r);
		outstanding++;
	endtask

	task automatic add_random(int n, int unsigned push_pct);
		logic [erq_pkg::KIND_W-1:0] k;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(15) == 0) ? erq_pkg::KIND_NONE
				: erq_pkg::KIND_W'($urandom_range(255, 1));
			add_req(($urandom_range(99) < push_pct) ? erq_pkg::REQ_PUSH : erq_pkg::REQ_POP,
				k, $urandom, {$urandom, $urandom});
		end
	endtask

	task automatic settle();
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_enable(logic [erq_pkg::APB_DATA_W-1:0] value);
		settle();
		// let the result pipeline empty before touching the register
		repeat (3) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= erq_pkg::REG_QUEUE_ENABLED;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ring_on = value[0];
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = erq_pkg::REQ_PUSH;
		req_ch.event_kind = '0;
		req_ch.event_source = '0;
		req_ch.event_payload = '0;
		rsp_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		wr_ptr = '0;
		rd_ptr = '0;
		push_total = '0;
		drop_total = '0;
		pop_total = '0;
		ring_on = 1'b0;
		send_idle_pct = 33;
		take_idle_pct = 74;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// disabled after reset: refuse everything
		add_req(erq_pkg::REQ_PUSH, 8'h05, 32'h1234_5678, 64'h0123_4567_89AB_CDEF);
		add_req(erq_pkg::REQ_POP, '0, '0, '0);
		write_enable(32'hFFFF_FFFF);

		add_req(erq_pkg::REQ_POP, 8'hFF, 32'hFFFF_FFFF, '1);
		add_req(erq_pkg::REQ_PUSH, erq_pkg::KIND_NONE, 32'hFFFF_FFFF, '1);
		add_req(erq_pkg::REQ_PUSH, 8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		add_req(erq_pkg::REQ_PUSH, 8'h01, 32'h0000_0000, 64'h0000_0000_0000_0000);
		add_req(erq_pkg::REQ_PUSH, 8'h80, 32'h8000_0000, 64'h8000_0000_0000_0001);
		add_req(erq_pkg::REQ_PUSH, 8'h55, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		repeat (5) add_req(erq_pkg::REQ_POP, 8'($urandom), $urandom, {$urandom, $urandom});
		add_req(erq_pkg::REQ_PUSH, 8'hAA, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555);

		// upper data bits are ignored: this disables with one event held
		write_enable(32'hFFFF_FFFE);
		add_req(erq_pkg::REQ_POP, '0, '0, '0);
		add_req(erq_pkg::REQ_PUSH, 8'h3C, 32'hC3C3_C3C3, 64'h3C3C_3C3C_3C3C_3C3C);
		write_enable(32'h0000_0001);

		// push-heavy traffic towards full, then pop-heavy traffic to drain
		add_random(300, 95);
		add_random(180, 8);
		write_enable($urandom & 32'hFFFF_FFFE);
		add_random(20, 50);
		write_enable($urandom | 32'h0000_0001);

		settle();
		send_idle_pct = 74;
		take_idle_pct = 33;
		add_random(160, 50);
		add_random(320, 92);

		settle();
		send_idle_pct = 0;
		take_idle_pct = 0;
		add_random(300, 5);
		add_random(150, 70);

		settle();
		repeat (6) @(posedge clk);
		if (fault_count == 0 && awaited_outcomes.size() == 0) begin
			$display("[event_ring_queue_with_drop_stats_top] OK");
		end else begin
			$display("[event_ring_queue_with_drop_stats_top] ERROR");
		end
		$finish;
	end

endmodule
